// ----- rtl/positional_list_engine_assert.svh -----
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion forms, clocked and gated by the async reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// condition holds at every edge out of reset
`define PLE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PLE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Types and constants shared by the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 8;
	localparam int REQ_W        = 3;
	localparam int STATUS_W     = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND    = 3'd0,
		REQ_PREPEND   = 3'd1,
		REQ_INSERT    = 3'd2,
		REQ_READ_ALL  = 3'd3,
		REQ_UPDATE    = 3'd4,
		REQ_DEL_FIRST = 3'd5,
		REQ_DEL_LAST  = 3'd6,
		REQ_DEL_AT    = 3'd7
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// operation broadcast along the row
	typedef enum logic [2:0] {
		COP_HOLD,
		COP_INSERT,
		COP_WRITE,
		COP_REMOVE,
		COP_ROTATE
	} cell_op_t;

	// what one cell loads this cycle
	typedef enum logic [2:0] {
		CM_KEEP,
		CM_LOAD,
		CM_FROM_LEFT,
		CM_FROM_RIGHT,
		CM_FROM_HEAD
	} cell_mode_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0]  value;
	} cell_cmd_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_READ
	} fsm_t;

endpackage

// ----- rtl/ple_req_if.sv -----
// ----------------------------------------------------------------------------
// ple_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface ple_req_if import ple_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [REQ_W-1:0]          req_type;
	logic [POS_W-1:0]          position;
	logic signed [DATA_W-1:0]  value;

	modport source (output valid, output req_type, output position, output value,
		input ready);
	modport sink (input valid, input req_type, input position, input value,
		output ready);
endinterface

// ----- rtl/ple_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ple_rsp_if
// Response channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface ple_rsp_if import ple_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [DATA_W-1:0]  value_out;
	logic                      last;

	modport source (output valid, output status, output value_out, output last,
		input ready);
	modport sink (input valid, input status, input value_out, input last,
		output ready);
endinterface

// ----- rtl/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds a value and loads from its neighbors, the head or
// the new value as the row tells it.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; (
	input  logic                      clk,
	input  cell_mode_t                mode,
	input  logic signed [DATA_W-1:0]  left,
	input  logic signed [DATA_W-1:0]  right,
	input  logic signed [DATA_W-1:0]  head,
	input  logic signed [DATA_W-1:0]  load,
	output logic signed [DATA_W-1:0]  data
);

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (mode)
			CM_LOAD:       data_q <= load;
			CM_FROM_LEFT:  data_q <= left;
			CM_FROM_RIGHT: data_q <= right;
			CM_FROM_HEAD:  data_q <= head;
			default:       data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ----- rtl/ple_cell_row.sv -----
// ----------------------------------------------------------------------------
// ple_cell_row
// Chain of list cells, front at cell 0. Decodes the broadcast operation
// into a per-cell mode from the cell's own index.
// ----------------------------------------------------------------------------
module ple_cell_row import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                      clk,
	input  cell_cmd_t                 cmd,
	input  logic [IW-1:0]             idx,
	input  logic [IW-1:0]             tail,
	output logic signed [DATA_W-1:0]  head
);

	logic signed [DATA_W-1:0] data [CAPACITY];

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam logic [IW-1:0] MY_IDX = IW'(g);
		cell_mode_t               mode;
		logic signed [DATA_W-1:0] left;
		logic signed [DATA_W-1:0] right;

		if (g == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid
			assign left = data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_end
			assign right = '0;
		end else begin : g_body
			assign right = data[g+1];
		end

		always_comb begin
			mode = CM_KEEP;
			case (cmd.op)
				COP_INSERT: begin
					if (MY_IDX == idx)
						mode = CM_LOAD;
					else if (MY_IDX > idx)
						mode = CM_FROM_LEFT;
				end
				COP_WRITE: begin
					if (MY_IDX == idx)
						mode = CM_LOAD;
				end
				COP_REMOVE: begin
					if (MY_IDX >= idx && g != CAPACITY - 1)
						mode = CM_FROM_RIGHT;
				end
				COP_ROTATE: begin
					// front word goes round to the tail
					if (MY_IDX == tail)
						mode = CM_FROM_HEAD;
					else if (MY_IDX < tail)
						mode = CM_FROM_RIGHT;
				end
				default: mode = CM_KEEP;
			endcase
		end

		ple_cell u_cell (
			.clk   (clk),
			.mode  (mode),
			.left  (left),
			.right (right),
			.head  (data[0]),
			.load  (cmd.value),
			.data  (data[g])
		);
	end

	assign head = data[0];

endmodule

// ----- rtl/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values in a chain of shifting cells, with
// append, prepend, positional insert, update, deletes and full read-out.
// ----------------------------------------------------------------------------
//  channel  dir  fields                        one word means
//  req      in   req_type, position, value     one request
//  rsp      out  status, value_out, last       one result, last marks the end
//
//  A single-result request has its result registered in the cycle after it is
//  taken, and a new request is taken in the cycle that result is read.
//  During a read-out the cell chain rotates one place per word, so the head
//  cell feeds the output and the list ends up unchanged.
//  Reset clears the length, state, read count and output valid; cell contents are undefined until written.
//  Requests are held off during a read-out and while a result is stalled.
// ----------------------------------------------------------------------------
`include "positional_list_engine_assert.svh"

module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > POS_W) ? LW : POS_W;

	fsm_t state_q, state_d;
	logic [LW-1:0] len_q;
	logic [IW-1:0] cnt_q;

	logic                      ov_q;
	status_t                   ost_q;
	logic signed [DATA_W-1:0]  oval_q;
	logic                      olast_q;

	logic out_free, in_fire, rot_en, ready_int, rot_last;
	logic [IW-1:0] tail;
	logic signed [DATA_W-1:0] head;

	// request decode
	logic [CW-1:0] posx, lenx;
	logic          full, empty, pos_in;
	logic [IW-1:0] pidx;
	status_t       dec_st;
	cell_op_t      dec_op;
	logic [IW-1:0] dec_idx;
	logic          dec_inc, dec_dec, dec_read;

	cell_cmd_t     cmd;
	logic [IW-1:0] cmd_idx;

	assign out_free = !ov_q || rsp.ready;
	assign in_fire  = req.valid && ready_int;
	assign tail     = IW'(len_q - LW'(1));
	assign rot_last = (cnt_q == tail);

	always_comb begin
		posx    = CW'(req.position);
		lenx    = CW'(len_q);
		full    = (len_q == LW'(CAPACITY));
		empty   = (len_q == '0);
		pos_in  = (posx != '0) && (posx <= lenx);
		pidx    = IW'(req.position - POS_W'(1));
		dec_st  = ST_OK;
		dec_op  = COP_HOLD;
		dec_idx = '0;
		dec_inc = 1'b0;
		dec_dec = 1'b0;
		dec_read = 1'b0;
		case (req_type_t'(req.req_type))
			REQ_APPEND: begin
				if (full) begin
					dec_st = ST_FULL;
				end else begin
					dec_op  = COP_INSERT;
					dec_idx = IW'(len_q);
					dec_inc = 1'b1;
				end
			end
			REQ_PREPEND: begin
				if (full) begin
					dec_st = ST_FULL;
				end else begin
					dec_op  = COP_INSERT;
					dec_inc = 1'b1;
				end
			end
			REQ_INSERT: begin
				if (full) begin
					dec_st = ST_FULL;
				end else if (posx == CW'(1) || pos_in) begin
					dec_op  = COP_INSERT;
					dec_idx = pidx;
					dec_inc = 1'b1;
				end else begin
					dec_st = ST_BADPOS;
				end
			end
			REQ_READ_ALL: begin
				if (empty)
					dec_st = ST_EMPTY;
				else
					dec_read = 1'b1;
			end
			REQ_UPDATE: begin
				if (empty) begin
					dec_st = ST_EMPTY;
				end else if (pos_in) begin
					dec_op  = COP_WRITE;
					dec_idx = pidx;
				end else begin
					dec_st = ST_BADPOS;
				end
			end
			REQ_DEL_FIRST: begin
				if (empty) begin
					dec_st = ST_EMPTY;
				end else begin
					dec_op  = COP_REMOVE;
					dec_dec = 1'b1;
				end
			end
			REQ_DEL_LAST: begin
				if (empty)
					dec_st = ST_EMPTY;
				else
					dec_dec = 1'b1;
			end
			REQ_DEL_AT: begin
				if (empty) begin
					dec_st = ST_EMPTY;
				end else if (pos_in) begin
					dec_op  = COP_REMOVE;
					dec_idx = pidx;
					dec_dec = 1'b1;
				end else begin
					dec_st = ST_BADPOS;
				end
			end
			default: dec_st = ST_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: if (in_fire && dec_read) state_d = FSM_READ;
			FSM_READ: if (rot_en && rot_last) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		ready_int = 1'b0;
		rot_en    = 1'b0;
		case (state_q)
			FSM_IDLE: ready_int = out_free;
			FSM_READ: rot_en    = out_free;
			default:  ready_int = 1'b0;
		endcase
	end

	always_comb begin
		cmd.value = req.value;
		cmd.op    = COP_HOLD;
		cmd_idx   = dec_idx;
		if (in_fire)
			cmd.op = dec_op;
		else if (rot_en)
			cmd.op = COP_ROTATE;
	end

	ple_cell_row #(.CAPACITY(CAPACITY)) u_row (
		.clk  (clk),
		.cmd  (cmd),
		.idx  (cmd_idx),
		.tail (tail),
		.head (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			len_q   <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && dec_inc)
				len_q <= len_q + LW'(1);
			else if (in_fire && dec_dec)
				len_q <= len_q - LW'(1);
			if (in_fire && dec_read)
				cnt_q <= '0;
			else if (rot_en)
				cnt_q <= cnt_q + IW'(1);
			if ((in_fire && !dec_read) || rot_en)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !dec_read) begin
			ost_q   <= dec_st;
			oval_q  <= '0;
			olast_q <= 1'b1;
		end else if (rot_en) begin
			ost_q   <= ST_OK;
			oval_q  <= head;
			olast_q <= rot_last;
		end
	end

	assign req.ready     = ready_int;
	assign rsp.valid     = ov_q;
	assign rsp.status    = ost_q;
	assign rsp.value_out = oval_q;
	assign rsp.last      = olast_q;

	`PLE_ASSERT_ALWAYS(a_len_cap, clk, arst_n, len_q <= LW'(CAPACITY),
		"length above capacity")
	`PLE_ASSERT_IMPL(a_read_cnt, clk, arst_n, state_q == FSM_READ,
		LW'(cnt_q) < len_q, "read count past length")
	`PLE_ASSERT_NEXT(a_del_last, clk, arst_n,
		in_fire && req.req_type == REQ_DEL_LAST && !empty,
		len_q == $past(len_q) - LW'(1), "delete last did not shrink list")
	`PLE_ASSERT_NEXT(a_read_end, clk, arst_n, rot_en && rot_last,
		state_q == FSM_IDLE && rsp.valid && rsp.last, "read-out end not marked")

endmodule
